// ===== hw/rtl/sal_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, codes and controller/datapath interface types for the sorted list.
package sal_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    localparam int S_FIELDS_W = VALUE_W + INDEX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + POS_W + COUNT_W + 2;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT    = 3'd0,
        ACT_SEARCH    = 3'd1,
        ACT_RMV_VALUE = 3'd2,
        ACT_RMV_INDEX = 3'd3,
        ACT_RMV_LAST  = 3'd4,
        ACT_CLEAR     = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    bs_read;
        logic    bs_step;
        logic    bs_upper;
        logic    chk_read;
        logic    ptr_load_cnt;
        logic    ptr_load_lo;
        logic    ptr_load_idx;
        logic    up_read;
        logic    up_write;
        logic    dn_read;
        logic    dn_write;
        logic    ins_write;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    pos_from_lo;
        logic    pos_from_idx;
        logic    pos_from_last;
        logic    emit;
        status_t status;
    } sal_cmd_t;

    // Datapath to controller
    typedef struct packed {
        action_t action;
        logic    full;
        logic    empty;
        logic    idx_ge_count;
        logic    lo_lt_hi;
        logic    lo_lt_count;
        logic    hit;
        logic    ptr_gt_lo;
        logic    ptr_next_lt_count;
        logic    out_busy;
    } sal_stat_t;

endpackage

// ===== hw/rtl/sal_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the sorted list: entry memory, search bounds, shift pointer and result register.
module sal_datapath
    import sal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sal_cmd_t              cmd,
    output sal_stat_t             stat,
    input  logic [S_TDATA_W-1:0]  in_data,
    input  logic [ACTION_W-1:0]   in_action,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [M_TDATA_W-1:0]  out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [INDEX_W-1:0]        index_reg;
    action_t                   action_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] count_dec;
    logic          go_right;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic signed [VALUE_W-1:0] wr_data;
    logic          list_empty;
    logic          is_full;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CW:1];
    assign ptr_dec   = ptr_reg - 1'b1;
    assign ptr_inc   = ptr_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign list_empty = (count_reg == '0);
    assign is_full   = (count_reg == CW'(CAPACITY));
    // Upper bound steps past equal entries, lower bound stops on them
    assign go_right  = cmd.bs_upper ? (rd_data_reg <= value_reg) : (rd_data_reg < value_reg);

    always_comb
    begin
        priority if (cmd.bs_read)
            rd_addr = mid[AW-1:0];
        else if (cmd.chk_read)
            rd_addr = lo_reg[AW-1:0];
        else if (cmd.up_read)
            rd_addr = ptr_dec[AW-1:0];
        else if (cmd.dn_read)
            rd_addr = ptr_inc[AW-1:0];
        else
            rd_addr = '0;
    end

    assign wr_en   = cmd.up_write | cmd.dn_write | cmd.ins_write;
    assign wr_addr = cmd.ins_write ? lo_reg[AW-1:0] : ptr_reg[AW-1:0];
    assign wr_data = cmd.ins_write ? value_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= $signed(in_data[VALUE_W-1:0]);
            index_reg <= in_data[S_FIELDS_W-1:VALUE_W];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_write)
            count_next = count_reg + 1'b1;
        else if (cmd.cnt_dec)
            count_next = count_dec;
        else if (cmd.cnt_clr)
            count_next = '0;

        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.load)
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        else if (cmd.bs_step)
        begin
            if (go_right)
                lo_next = mid + 1'b1;
            else
                hi_next = mid;
        end

        ptr_next = ptr_reg;
        if (cmd.ptr_load_cnt)
            ptr_next = count_reg;
        else if (cmd.ptr_load_lo)
            ptr_next = lo_reg;
        else if (cmd.ptr_load_idx)
            ptr_next = CW'(index_reg);
        else if (cmd.up_write)
            ptr_next = ptr_dec;
        else if (cmd.dn_write)
            ptr_next = ptr_inc;

        pos_next = pos_reg;
        if (cmd.load)
            pos_next = '0;
        else if (cmd.pos_from_lo)
            pos_next = POS_W'(lo_reg);
        else if (cmd.pos_from_idx)
            pos_next = POS_W'(index_reg);
        else if (cmd.pos_from_last)
            pos_next = POS_W'(count_dec);

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = M_TDATA_W'({is_full, list_empty, COUNT_W'(count_reg),
                                         pos_reg, cmd.status});
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            action_reg    <= ACT_INSERT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                action_reg <= action_t'(in_action);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        stat                   = '0;
        stat.action            = action_reg;
        stat.full              = is_full;
        stat.empty             = list_empty;
        stat.idx_ge_count      = (XW'(index_reg) >= XW'(count_reg));
        stat.lo_lt_hi          = (lo_reg < hi_reg);
        stat.lo_lt_count       = (lo_reg < count_reg);
        stat.hit               = (rd_data_reg == value_reg);
        stat.ptr_gt_lo         = (ptr_reg > lo_reg);
        stat.ptr_next_lt_count = (ptr_inc < count_reg);
        stat.out_busy          = out_valid_reg & ~out_ready;
    end

endmodule

// ===== hw/rtl/sal_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the sorted list: sequences search, shift and result steps.
module sal_ctrl
    import sal_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sal_stat_t stat,
    output sal_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BS_RD,
        S_BS_CMP,
        S_HIT_CHK,
        S_UP_CHK,
        S_UP_WR,
        S_DN_CHK,
        S_DN_WR,
        S_FINISH
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    always_comb
    begin
        cmd          = '0;
        cmd.status   = status_reg;
        cmd.bs_upper = (stat.action == ACT_INSERT);
        state_next   = state_reg;
        status_next  = status_reg;
        in_ready     = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.action)
                    ACT_INSERT:
                    begin
                        if (stat.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_BS_RD;
                        end
                    end
                    ACT_SEARCH, ACT_RMV_VALUE:
                    begin
                        state_next = S_BS_RD;
                    end
                    ACT_RMV_INDEX:
                    begin
                        if (stat.empty)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else if (stat.idx_ge_count)
                        begin
                            status_next = ST_BAD_INDEX;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cmd.ptr_load_idx = 1'b1;
                            cmd.pos_from_idx = 1'b1;
                            state_next       = S_DN_CHK;
                        end
                    end
                    ACT_RMV_LAST:
                    begin
                        if (stat.empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.cnt_dec       = 1'b1;
                            cmd.pos_from_last = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_BS_RD:
            begin
                if (stat.lo_lt_hi)
                begin
                    cmd.bs_read = 1'b1;
                    state_next  = S_BS_CMP;
                end
                else if (stat.action == ACT_INSERT)
                begin
                    cmd.ptr_load_cnt = 1'b1;
                    cmd.pos_from_lo  = 1'b1;
                    state_next       = S_UP_CHK;
                end
                else if (stat.lo_lt_count)
                begin
                    cmd.chk_read = 1'b1;
                    state_next   = S_HIT_CHK;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
            end
            S_BS_CMP:
            begin
                cmd.bs_step = 1'b1;
                state_next  = S_BS_RD;
            end
            S_HIT_CHK:
            begin
                if (stat.hit)
                begin
                    cmd.pos_from_lo = 1'b1;
                    if (stat.action == ACT_RMV_VALUE)
                    begin
                        cmd.ptr_load_lo = 1'b1;
                        state_next      = S_DN_CHK;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
            end
            S_UP_CHK:
            begin
                // Move larger entries up one slot, top first, then drop the value in
                if (stat.ptr_gt_lo)
                begin
                    cmd.up_read = 1'b1;
                    state_next  = S_UP_WR;
                end
                else
                begin
                    cmd.ins_write = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_UP_WR:
            begin
                cmd.up_write = 1'b1;
                state_next   = S_UP_CHK;
            end
            S_DN_CHK:
            begin
                if (stat.ptr_next_lt_count)
                begin
                    cmd.dn_read = 1'b1;
                    state_next  = S_DN_WR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_DN_WR:
            begin
                cmd.dn_write = 1'b1;
                state_next   = S_DN_CHK;
            end
            S_FINISH:
            begin
                // Hold until the result register is free
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== hw/rtl/sorted_array_list.sv =====
`timescale 1ns / 1ps
// Top level of the sorted list: ascending list of signed words with stream ports.
//
//  Channel | Direction | Handshake                    | Payload
//  --------+-----------+------------------------------+---------------------------------------
//  s_axis  | in        | s_axis_tvalid/s_axis_tready  | tuser: action; tdata: value, index
//  m_axis  | out       | m_axis_tvalid/m_axis_tready  | tdata: status, position, count, flags
//
// One item at a time. A binary search step is a memory read followed by a compare; every
// entry moved by insert or remove takes a read step and a write step on the entry memory.
// Clear, remove last and rejected actions go from dispatch straight to the result.
// Reset clears the count; entries are not cleared and only positions below count are read.
// A stalled result waits in the output register; the next beat is accepted meanwhile.
module sorted_array_list
    import sal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // value[31:0], index[37:32]
    input  logic [ACTION_W-1:0]  s_axis_tuser,  // action[2:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // status[2:0], position[8:3], count[15:9],
                                                // list_empty[16], is_full[17]
);

    sal_cmd_t  cmd;
    sal_stat_t stat;

    sal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sal_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_action (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== hw/rtl/sal_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sorted list, bound to the top level.
module sal_checker
    import sal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0] r_status;
    logic [POS_W-1:0]    r_pos;
    logic [COUNT_W-1:0]  r_count;
    logic                r_empty;
    logic                r_full;
    logic                in_fire;

    assign r_status = m_axis_tdata[STATUS_W-1:0];
    assign r_pos    = m_axis_tdata[STATUS_W+POS_W-1:STATUS_W];
    assign r_count  = m_axis_tdata[STATUS_W+POS_W+COUNT_W-1:STATUS_W+POS_W];
    assign r_empty  = m_axis_tdata[STATUS_W+POS_W+COUNT_W];
    assign r_full   = m_axis_tdata[STATUS_W+POS_W+COUNT_W+1];
    assign in_fire  = s_axis_tvalid & s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second beat taken while an item is in progress");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (r_empty == (r_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_full |-> (r_count == COUNT_W'(CAPACITY)) && !r_empty)
        else $error("full flag disagrees with count");

    a_pos_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (r_status != ST_OK) |-> (r_pos == '0))
        else $error("nonzero position on a failed action");

endmodule

bind sorted_array_list sal_checker #(
    .CAPACITY (CAPACITY)
) u_sal_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
